// File: hw/rtl/imu_fmt_pkg.sv
// shared types and constants for the imu sample ascii formatter
// used by imu_fmt_conv and imu_sample_ascii_formatter, no dependencies
package imu_fmt_pkg;

    localparam int LINE_LEN = 55;
    localparam int NUM_CH   = 6;
    localparam int NUM_GYRO = 3;

    typedef logic [15:0] raw_t;

    // one printed value: sign flag and three decimal digits
    typedef struct packed {
        logic       neg;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } dec_t;

    // stage load strobes for the conversion pipeline
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_line;
    } conv_ctl_t;

endpackage

// File: hw/rtl/imu_sample_ascii_formatter.sv
// top level of the imu sample ascii formatter: filter, stage control, byte output
// depends on imu_fmt_pkg and imu_fmt_conv
//
//  channel | handshake          | payload
//  s_      | s_valid / s_ready  | gyro x,y,z, accel x,y,z, sample_id, sample_valid
//  m_      | m_valid / m_ready  | out_byte, line_end (high on the final LF)
//
// a sample that is emitted gives 55 bytes, one per cycle while m_ready is high,
// so the byte output sets the pace of a steady stream.
// the first byte shows once the sample has passed the input and conversion stages.
// up to three samples wait in the input register and conversion stages while a line drains.
// synchronous active-low reset empties all stages and clears the last sent id.
module imu_sample_ascii_formatter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_gyro_z,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic        [31:0] s_sample_id,
    input  logic               s_sample_valid,
    output logic               m_valid,
    input  logic               m_ready,
    output logic        [7:0]  m_out_byte,
    output logic               m_line_end
);
    import imu_fmt_pkg::*;

    localparam int NUM_STG   = 4;
    localparam logic [5:0] LAST_POS = 6'(LINE_LEN - 1);
    localparam int GYRO_POS  = 10;
    localparam int GYRO_STEP = 5;
    localparam int ACC_POS   = 34;
    localparam int ACC_STEP  = 7;
    localparam logic [LINE_LEN*8-1:0] TEMPLATE =
        "Drehrate: +000 +000 +000; Linear: +00.0, +00.0, +00.0\r\n";

    logic [NUM_STG-1:0] vld_reg, vld_next;
    logic [NUM_STG-1:0] leave;
    logic [NUM_STG-1:0] free;
    logic [NUM_STG-1:0] load;
    logic [5:0]         pos_reg, pos_next;
    logic [31:0]        last_id_reg, last_id_next;
    raw_t [NUM_CH-1:0]  raw_reg;
    logic               accept;
    logic               emit;
    logic               line_done;
    conv_ctl_t          ctl;
    dec_t [NUM_CH-1:0]  dec;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    function automatic logic [7:0] sign_char(input logic neg);
        return neg ? 8'h2d : 8'h2b;
    endfunction

    function automatic logic [7:0] line_char(input logic [5:0] pos,
                                             input dec_t [NUM_CH-1:0] d);
        logic [7:0] c;
        c = TEMPLATE[8*(LINE_LEN-1-int'(pos)) +: 8];
        for (int k = 0; k < NUM_GYRO; k++) begin
            if (pos == 6'(GYRO_POS + GYRO_STEP*k))     c = sign_char(d[k].neg);
            if (pos == 6'(GYRO_POS + GYRO_STEP*k + 1)) c = digit_char(d[k].d2);
            if (pos == 6'(GYRO_POS + GYRO_STEP*k + 2)) c = digit_char(d[k].d1);
            if (pos == 6'(GYRO_POS + GYRO_STEP*k + 3)) c = digit_char(d[k].d0);
            if (pos == 6'(ACC_POS + ACC_STEP*k))       c = sign_char(d[NUM_GYRO+k].neg);
            if (pos == 6'(ACC_POS + ACC_STEP*k + 1))   c = digit_char(d[NUM_GYRO+k].d2);
            if (pos == 6'(ACC_POS + ACC_STEP*k + 2))   c = digit_char(d[NUM_GYRO+k].d1);
            if (pos == 6'(ACC_POS + ACC_STEP*k + 4))   c = digit_char(d[NUM_GYRO+k].d0);
        end
        return c;
    endfunction

    // stage handoff: 0 input register, 1 and 2 conversion, 3 line being sent
    always_comb begin
        line_done = vld_reg[NUM_STG-1] && m_ready && (pos_reg == LAST_POS);
        leave[NUM_STG-1] = line_done;
        free[NUM_STG-1]  = !vld_reg[NUM_STG-1] || line_done;
        for (int i = NUM_STG-2; i >= 0; i--) begin
            leave[i] = vld_reg[i] && free[i+1];
            free[i]  = !vld_reg[i] || leave[i];
        end
    end

    assign s_ready = free[0];
    assign accept  = s_valid && s_ready;
    // repeated or invalid samples are dropped at the input
    assign emit    = accept && s_sample_valid && (s_sample_id != last_id_reg);

    always_comb begin
        load[0] = emit;
        for (int i = 1; i < NUM_STG; i++) begin
            load[i] = leave[i-1];
        end
        for (int i = 0; i < NUM_STG; i++) begin
            vld_next[i] = (vld_reg[i] && !leave[i]) || load[i];
        end
        last_id_next = emit ? s_sample_id : last_id_reg;
        pos_next     = pos_reg;
        if (m_valid && m_ready) begin
            pos_next = (pos_reg == LAST_POS) ? 6'd0 : pos_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            pos_reg     <= '0;
            last_id_reg <= '0;
        end else begin
            vld_reg     <= vld_next;
            pos_reg     <= pos_next;
            last_id_reg <= last_id_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            raw_reg <= {s_accel_z, s_accel_y, s_accel_x, s_gyro_z, s_gyro_y, s_gyro_x};
        end
    end

    assign ctl.load_a    = load[1];
    assign ctl.load_b    = load[2];
    assign ctl.load_line = load[3];

    imu_fmt_conv u_conv (
        .aclk    (aclk),
        .ctl     (ctl),
        .raw_in  (raw_reg),
        .dec_out (dec)
    );

    assign m_valid    = vld_reg[NUM_STG-1];
    assign m_out_byte = line_char(pos_reg, dec);
    assign m_line_end = (pos_reg == LAST_POS);

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pos_reg <= LAST_POS)
        else $error("byte position past end of line");

    a_pos_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_line_end) |=> pos_reg == 6'd0)
        else $error("byte position did not restart after line end");

    a_last_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_sample_valid && s_sample_id != last_id_reg)
        |=> last_id_reg == $past(s_sample_id))
        else $error("last sent id not updated on emitted sample");

    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> pos_reg == 6'd0)
        else $error("byte position nonzero with no line in progress");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("input stalled with empty input register");

endmodule

// File: hw/rtl/imu_fmt_conv.sv
// scaling, rounding, clamping and decimal split of the six sensor axes
// three register stages, each loaded by a strobe from the top level; uses imu_fmt_pkg
module imu_fmt_conv (
    input  logic                                          aclk,
    input  imu_fmt_pkg::conv_ctl_t                        ctl,
    input  imu_fmt_pkg::raw_t [imu_fmt_pkg::NUM_CH-1:0]   raw_in,
    output imu_fmt_pkg::dec_t [imu_fmt_pkg::NUM_CH-1:0]   dec_out
);
    import imu_fmt_pkg::*;

    // floor(y / 41) == (y * GYRO_RECIP) >> 21 for y up to 40980
    localparam logic [15:0] GYRO_RECIP = 16'd51151;
    localparam logic [22:0] HUND_RECIP = 23'd5243;
    localparam logic [14:0] TEN_RECIP  = 15'd205;
    localparam logic [10:0] MAX_VAL    = 11'd999;

    logic [16:0] mag [NUM_CH];
    logic        neg [NUM_CH];

    logic [18:0] gyro_sum [NUM_GYRO];
    logic [31:0] gyro_prod_next [NUM_GYRO];
    logic [31:0] gyro_prod_reg [NUM_GYRO];
    logic [20:0] accel_sum [NUM_GYRO];
    logic [10:0] accel_q_next [NUM_GYRO];
    logic [10:0] accel_q_reg [NUM_GYRO];
    logic        a_neg_reg [NUM_CH];

    logic [10:0] q_raw [NUM_CH];
    logic [9:0]  b_q_next [NUM_CH];
    logic [9:0]  b_q_reg [NUM_CH];
    logic [22:0] b_hprod_next [NUM_CH];
    logic [22:0] b_hprod_reg [NUM_CH];
    logic        b_sgn_next [NUM_CH];
    logic        b_sgn_reg [NUM_CH];

    logic [3:0]  hund [NUM_CH];
    logic [9:0]  rem10 [NUM_CH];
    logic [6:0]  rem [NUM_CH];
    logic [14:0] tprod [NUM_CH];
    logic [3:0]  tens [NUM_CH];
    logic [6:0]  ones [NUM_CH];
    dec_t [NUM_CH-1:0] dec_next;
    dec_t [NUM_CH-1:0] dec_reg;

    // stage a: sign and magnitude, gyro reciprocal product, accel shift
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            neg[i] = raw_in[i][15];
            mag[i] = raw_in[i][15] ? (17'h10000 - {1'b0, raw_in[i]}) : {1'b0, raw_in[i]};
        end
        for (int i = 0; i < NUM_GYRO; i++) begin
            // (mag*10 + 164) / 328 == ((mag*5 + 82) >> 2) / 41
            gyro_sum[i]       = {mag[i], 2'b00} + {2'b00, mag[i]} + 19'd82;
            gyro_prod_next[i] = {16'd0, gyro_sum[i][17:2]} * {16'd0, GYRO_RECIP};
            // (mag*98 + 1024) / 2048 == (mag*49 + 512) >> 10
            accel_sum[i]      = 21'({mag[NUM_GYRO+i], 5'b0}) + 21'({mag[NUM_GYRO+i], 4'b0})
                              + 21'(mag[NUM_GYRO+i]) + 21'd512;
            accel_q_next[i]   = accel_sum[i][20:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            for (int i = 0; i < NUM_GYRO; i++) begin
                gyro_prod_reg[i] <= gyro_prod_next[i];
                accel_q_reg[i]   <= accel_q_next[i];
            end
            for (int i = 0; i < NUM_CH; i++) begin
                a_neg_reg[i] <= neg[i];
            end
        end
    end

    // stage b: clamp, sign display, hundreds reciprocal product
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            q_raw[i] = (i < NUM_GYRO) ? gyro_prod_reg[i % NUM_GYRO][31:21]
                                      : accel_q_reg[i % NUM_GYRO];
            b_q_next[i]     = (q_raw[i] > MAX_VAL) ? MAX_VAL[9:0] : q_raw[i][9:0];
            b_hprod_next[i] = {13'd0, b_q_next[i]} * HUND_RECIP;
            // a value that rounds to zero prints with a plus sign
            b_sgn_next[i]   = a_neg_reg[i] && (b_q_next[i] != 10'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_b) begin
            for (int i = 0; i < NUM_CH; i++) begin
                b_q_reg[i]     <= b_q_next[i];
                b_hprod_reg[i] <= b_hprod_next[i];
                b_sgn_reg[i]   <= b_sgn_next[i];
            end
        end
    end

    // stage c: hundreds digit, tens and ones
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            hund[i]  = b_hprod_reg[i][22:19];
            rem10[i] = b_q_reg[i] - ({6'd0, hund[i]} * 10'd100);
            rem[i]   = rem10[i][6:0];
            tprod[i] = {8'd0, rem[i]} * TEN_RECIP;
            tens[i]  = tprod[i][14:11];
            ones[i]  = rem[i] - ({3'd0, tens[i]} * 7'd10);
            dec_next[i].neg = b_sgn_reg[i];
            dec_next[i].d2  = hund[i];
            dec_next[i].d1  = tens[i];
            dec_next[i].d0  = ones[i][3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_line) begin
            dec_reg <= dec_next;
        end
    end

    assign dec_out = dec_reg;

endmodule

// File: sim/imu_line_checker.sv
// checker for the imu sample ascii formatter: predicts each text line and compares it
// against the byte stream on the m_ channel, depends on nothing beyond the port list
`timescale 1ns / 100ps

module imu_line_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_gyro_x,
    input  logic signed [15:0] s_gyro_y,
    input  logic signed [15:0] s_gyro_z,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic        [31:0] s_sample_id,
    input  logic               s_sample_valid,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic        [7:0]  m_out_byte,
    input  logic               m_line_end,
    output int                 mismatch_count,
    output int                 bytes_pending
);

    localparam int GYRO_MUL  = 10;
    localparam int GYRO_DIV  = 328;
    localparam int ACCEL_MUL = 98;
    localparam int ACCEL_DIV = 2048;
    localparam int MAX_MAG   = 999;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } line_char_t;

    line_char_t  line_chars_due[$];
    logic [31:0] last_sent_id;
    int          errs = 0;
    int          line_pos = 0;

    // scaled magnitude in display units, half away from zero, clamped
    function automatic int scaled_mag(input logic signed [15:0] raw, input int mul,
                                      input int div);
        int mag;
        int q;
        mag = (raw < 0) ? -int'(raw) : int'(raw);
        q = (mag * mul + div / 2) / div;
        return (q > MAX_MAG) ? MAX_MAG : q;
    endfunction

    task automatic queue_char(input logic [7:0] c, input logic eol);
        line_char_t item;
        item.ch  = c;
        item.eol = eol;
        line_chars_due.push_back(item);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], 1'b0);
    endtask

    // accel readings print as dd.d, gyro readings as ddd
    task automatic queue_reading(input logic signed [15:0] raw, input bit is_accel);
        int q;
        q = is_accel ? scaled_mag(raw, ACCEL_MUL, ACCEL_DIV)
                     : scaled_mag(raw, GYRO_MUL, GYRO_DIV);
        queue_char((raw < 0 && q != 0) ? "-" : "+", 1'b0);
        queue_char(8'(8'h30 + (q / 100) % 10), 1'b0);
        queue_char(8'(8'h30 + (q / 10) % 10), 1'b0);
        if (is_accel)
            queue_char(".", 1'b0);
        queue_char(8'(8'h30 + q % 10), 1'b0);
    endtask

    task automatic queue_line();
        queue_text("Drehrate: ");
        queue_reading(s_gyro_x, 1'b0);
        queue_text(" ");
        queue_reading(s_gyro_y, 1'b0);
        queue_text(" ");
        queue_reading(s_gyro_z, 1'b0);
        queue_text("; Linear: ");
        queue_reading(s_accel_x, 1'b1);
        queue_text(", ");
        queue_reading(s_accel_y, 1'b1);
        queue_text(", ");
        queue_reading(s_accel_z, 1'b1);
        queue_char(8'h0d, 1'b0);
        queue_char(8'h0a, 1'b1);
    endtask

    always @(posedge aclk) begin
        line_char_t want;
        if (!aresetn) begin
            last_sent_id <= '0;
            line_chars_due.delete();
            line_pos = 0;
        end else begin
            // invalid samples and repeated counters produce nothing
            if (s_valid && s_ready && s_sample_valid && s_sample_id != last_sent_id) begin
                queue_line();
                last_sent_id <= s_sample_id;
            end
            if (m_valid && m_ready) begin
                if (line_chars_due.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_MAX)
                        $display("%0t: unexpected byte 0x%02h line_end=%0b",
                                 $realtime, m_out_byte, m_line_end);
                end else begin
                    want = line_chars_due.pop_front();
                    if (m_out_byte !== want.ch || m_line_end !== want.eol) begin
                        errs++;
                        if (errs <= REPORT_MAX)
                            $display({"%0t: byte %0d of line: expected 0x%02h end=%0b,",
                                      " got 0x%02h end=%0b"},
                                     $realtime, line_pos, want.ch, want.eol,
                                     m_out_byte, m_line_end);
                    end
                    line_pos = want.eol ? 0 : line_pos + 1;
                end
            end
        end
        mismatch_count <= errs;
        bytes_pending  <= line_chars_due.size();
    end

endmodule

// File: sim/imu_sample_ascii_formatter_test.sv
// testbench top for the imu sample ascii formatter: clock, reset, sample stimulus, verdict
// depends on imu_sample_ascii_formatter and imu_line_checker
`timescale 1ns / 100ps

module imu_sample_ascii_formatter_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_GAP      = 10;
    localparam int TAIL_CYCLES  = 20;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_gyro_x;
    logic signed [15:0] s_gyro_y;
    logic signed [15:0] s_gyro_z;
    logic signed [15:0] s_accel_x;
    logic signed [15:0] s_accel_y;
    logic signed [15:0] s_accel_z;
    logic        [31:0] s_sample_id;
    logic               s_sample_valid;
    logic               m_valid;
    logic               m_ready;
    logic        [7:0]  m_out_byte;
    logic               m_line_end;

    int          mismatch_count;
    int          bytes_pending;
    int          cycle_count = 0;
    bit          steady_flow = 1'b0;
    logic [31:0] id_sent = '0;

    imu_sample_ascii_formatter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_gyro_x(s_gyro_x), .s_gyro_y(s_gyro_y), .s_gyro_z(s_gyro_z),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_sample_id(s_sample_id), .s_sample_valid(s_sample_valid),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_line_end(m_line_end)
    );

    imu_line_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_gyro_x(s_gyro_x), .s_gyro_y(s_gyro_y), .s_gyro_z(s_gyro_z),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_sample_id(s_sample_id), .s_sample_valid(s_sample_valid),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_byte(m_out_byte), .m_line_end(m_line_end),
        .mismatch_count(mismatch_count), .bytes_pending(bytes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [15:0] rand_axis();
        logic signed [15:0] v;
        case ($urandom_range(0, 3))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 60));
            2: v = 16'($urandom_range(20880, 20895));    // around the accel clamp
            default: v = 16'($urandom_range(32760, 32767));
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // result side: random stall before each transaction
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
        end
    end

    task automatic send_sample(input logic signed [15:0] gx, gy, gz, ax, ay, az,
                               input logic [31:0] id, input logic sv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_gyro_x       <= gx;
        s_gyro_y       <= gy;
        s_gyro_z       <= gz;
        s_accel_x      <= ax;
        s_accel_y      <= ay;
        s_accel_z      <= az;
        s_sample_id    <= id;
        s_sample_valid <= sv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (sv && id != id_sent)
            id_sent = id;
    endtask

    // hold the input side until every pending byte has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (bytes_pending != 0);
    endtask

    initial begin
        int kind;
        logic [31:0] id;
        s_valid        <= 1'b0;
        s_gyro_x       <= '0;
        s_gyro_y       <= '0;
        s_gyro_z       <= '0;
        s_accel_x      <= '0;
        s_accel_y      <= '0;
        s_accel_z      <= '0;
        s_sample_id    <= '0;
        s_sample_valid <= 1'b0;
        aresetn        <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // counter 0 right after reset repeats the cleared last id
        send_sample(0, 0, 0, 0, 0, 0, 32'd0, 1'b1);
        send_sample(0, 0, 0, 0, 0, 0, 32'd1, 1'b1);
        send_sample(100, 200, 300, 400, 500, 600, 32'd1, 1'b1);
        send_sample(100, 200, 300, 400, 500, 600, 32'd2, 1'b0);
        send_sample(32767, 32767, 32767, 32767, 32767, 32767, 32'd2, 1'b1);
        send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd3, 1'b1);
        // small negatives that round to zero print with a plus sign
        send_sample(-1, -16, -1, -1, -10, -1, 32'd4, 1'b1);
        send_sample(16, 17, -17, 10, 11, -11, 32'd5, 1'b1);
        send_sample(32767, -32768, 0, 20887, -20888, 20888, 32'd6, 1'b1);
        send_sample(-12345, 4321, -999, -5000, 15000, -20887, 32'hffff_ffff, 1'b1);
        send_sample(1, 2, 3, 4, 5, 6, 32'hffff_ffff, 1'b0);
        send_sample(-164, 164, -492, -1024, 1024, -3072, 32'd0, 1'b1);
        send_sample(7, 7, 7, 7, 7, 7, 32'd0, 1'b1);
        send_sample(16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0,
                    32'haaaa_5555, 1'b1);
        send_sample(-3280, 3280, -328, -2048, 2048, -21, 32'h5555_aaaa, 1'b1);
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            kind = $urandom_range(0, 9);
            case (kind)
                0: id = $urandom;
                1: id = id_sent;
                default: id = $urandom_range(0, 1) ? id_sent + 1 : $urandom;
            endcase
            send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
                        rand_axis(), id,
                        (kind == 0) ? 1'b0 : (kind == 2) ? 1'($urandom_range(0, 1)) : 1'b1);
        end

        steady_flow = 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && bytes_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
